// ----- sv/ttad_pkg.sv -----
// Shared types and constants for the teletext attribute decoder.
package ttad_pkg;

	typedef struct packed {
		logic [2:0] ink;
		logic [2:0] paper;
		logic [5:0] flags;
		logic [1:0] box;
	} attr_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] glyph_set;
		logic [4:0] glyph_code;
		logic [1:0] held_when;
		attr_t      attr;
		logic [5:0] cell_column;
		logic [4:0] cell_row;
	} result_t;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_LINE_WRAP   = 3'd1;
	localparam logic [2:0] ST_PAGE_WRAP   = 3'd2;
	localparam logic [2:0] ST_BAD_GLYPH   = 3'd3;
	localparam logic [2:0] ST_BAD_CONTROL = 3'd4;
	localparam logic [2:0] ST_BLACK_REF   = 3'd5;

	// glyph banks
	localparam logic [2:0] GS_NONE       = 3'd0;
	localparam logic [2:0] GS_GFX_LOW    = 3'd1;
	localparam logic [2:0] GS_ALPHA_LOW  = 3'd2;
	localparam logic [2:0] GS_ALPHA_MID  = 3'd3;
	localparam logic [2:0] GS_GFX_HIGH   = 3'd4;
	localparam logic [2:0] GS_ALPHA_HIGH = 3'd5;

	// held glyph timing
	localparam logic [1:0] HW_NONE   = 2'd0;
	localparam logic [1:0] HW_BEFORE = 2'd1;
	localparam logic [1:0] HW_AFTER  = 2'd2;

	// box phases
	localparam logic [1:0] BOX_OFF       = 2'd0;
	localparam logic [1:0] BOX_START_ONE = 2'd1;
	localparam logic [1:0] BOX_ON        = 2'd2;
	localparam logic [1:0] BOX_END_ONE   = 2'd3;

	// flag bit positions
	localparam int FL_FLASH     = 0;
	localparam int FL_CONCEAL   = 1;
	localparam int FL_DOUBLE    = 2;
	localparam int FL_GFX       = 3;
	localparam int FL_SEPARATED = 4;
	localparam int FL_HOLD      = 5;

	// control codes (low five bits)
	localparam logic [4:0] C_FLASH      = 5'h08;
	localparam logic [4:0] C_STEADY     = 5'h09;
	localparam logic [4:0] C_END_BOX    = 5'h0A;
	localparam logic [4:0] C_START_BOX  = 5'h0B;
	localparam logic [4:0] C_NORMAL_HT  = 5'h0C;
	localparam logic [4:0] C_DOUBLE_HT  = 5'h0D;
	localparam logic [4:0] C_SHIFT_OUT  = 5'h0E;
	localparam logic [4:0] C_SHIFT_IN   = 5'h0F;
	localparam logic [4:0] C_CONCEAL    = 5'h18;
	localparam logic [4:0] C_CONTIG     = 5'h19;
	localparam logic [4:0] C_SEPARATED  = 5'h1A;
	localparam logic [4:0] C_ESCAPE     = 5'h1B;
	localparam logic [4:0] C_BLACK_BG   = 5'h1C;
	localparam logic [4:0] C_NEW_BG     = 5'h1D;
	localparam logic [4:0] C_HOLD       = 5'h1E;
	localparam logic [4:0] C_RELEASE    = 5'h1F;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMNS   = 2'd0;
	localparam logic [1:0] REG_ROWS      = 2'd1;
	localparam logic [1:0] REG_BLACK_INK = 2'd2;

	// reset values
	localparam logic [6:0] COLUMNS_RST = 7'd40;
	localparam logic [5:0] ROWS_RST    = 6'd25;
	localparam attr_t ATTR_RST = '{ink: 3'd7, paper: 3'd0, flags: 6'd0, box: BOX_OFF};

endpackage

// ----- sv/ttad_decode.sv -----
// Combinational character decode, attribute update and cursor advance.
module ttad_decode #(
	parameter int MAX_COLUMNS,
	parameter int MAX_ROWS,
	localparam int CW = $clog2(MAX_COLUMNS),
	localparam int RW = $clog2(MAX_ROWS)
) (
	input  logic [7:0]        chr,
	input  ttad_pkg::attr_t   attr_cur,
	input  logic [CW-1:0]     col_cur,
	input  logic [RW-1:0]     row_cur,
	input  logic [6:0]        columns,
	input  logic [5:0]        rows,
	input  logic              black_ink_enable,
	output ttad_pkg::attr_t   attr_nxt,
	output logic [CW-1:0]     col_nxt,
	output logic [RW-1:0]     row_nxt,
	output ttad_pkg::result_t res
);

	logic            accepted;
	ttad_pkg::attr_t a;
	logic [4:0]      c5;
	logic [7:0]      width_eff;
	logic [7:0]      col_inc;
	logic [7:0]      col_wide;
	logic [7:0]      row_wide;
	logic [6:0]      height_eff;
	logic [6:0]      row_inc;

	assign c5 = chr[4:0];

	always_comb begin
		if (columns == 7'd0) begin
			width_eff = 8'd1;
		end else if (8'(columns) > 8'(MAX_COLUMNS)) begin
			width_eff = 8'(MAX_COLUMNS);
		end else begin
			width_eff = 8'(columns);
		end
		if (rows == 6'd0) begin
			height_eff = 7'd1;
		end else if (7'(rows) > 7'(MAX_ROWS)) begin
			height_eff = 7'(MAX_ROWS);
		end else begin
			height_eff = 7'(rows);
		end
	end

	always_comb begin
		a                 = attr_cur;
		accepted          = 1'b1;
		res.status        = ttad_pkg::ST_OK;
		res.glyph_set     = ttad_pkg::GS_NONE;
		res.glyph_code    = 5'd0;
		res.held_when     = ttad_pkg::HW_NONE;

		if (chr[7]) begin
			res.status = ttad_pkg::ST_BAD_GLYPH;
			accepted   = 1'b0;
		end else if (chr[6:5] == 2'b00) begin
			if (c5 == ttad_pkg::C_SHIFT_OUT || c5 == ttad_pkg::C_SHIFT_IN ||
			    c5 == ttad_pkg::C_ESCAPE) begin
				res.status = ttad_pkg::ST_BAD_CONTROL;
				accepted   = 1'b0;
			end else if (c5[3:0] == 4'd0 && !black_ink_enable) begin
				res.status = ttad_pkg::ST_BLACK_REF;
				accepted   = 1'b0;
			end else begin
				if (c5 == ttad_pkg::C_STEADY ||
				    (c5 >= ttad_pkg::C_CONTIG && c5 <= ttad_pkg::C_HOLD)) begin
					res.held_when = ttad_pkg::HW_AFTER;
				end else begin
					res.held_when = ttad_pkg::HW_BEFORE;
				end
				if (!c5[3]) begin
					a.ink = c5[2:0];
					if (c5[4]) begin
						a.flags[ttad_pkg::FL_GFX] = 1'b1;
					end else begin
						a.flags[ttad_pkg::FL_GFX]  = 1'b0;
						a.flags[ttad_pkg::FL_HOLD] = 1'b0;
					end
				end else begin
					unique case (c5)
						ttad_pkg::C_FLASH:     a.flags[ttad_pkg::FL_FLASH] = 1'b1;
						ttad_pkg::C_STEADY:    a.flags[ttad_pkg::FL_FLASH] = 1'b0;
						ttad_pkg::C_END_BOX: begin
							a.box = (attr_cur.box != ttad_pkg::BOX_END_ONE &&
							         attr_cur.box != ttad_pkg::BOX_OFF) ?
							        ttad_pkg::BOX_END_ONE : ttad_pkg::BOX_OFF;
						end
						ttad_pkg::C_START_BOX: begin
							a.box = (attr_cur.box != ttad_pkg::BOX_START_ONE &&
							         attr_cur.box != ttad_pkg::BOX_ON) ?
							        ttad_pkg::BOX_START_ONE : ttad_pkg::BOX_ON;
						end
						ttad_pkg::C_NORMAL_HT: begin
							if (attr_cur.flags[ttad_pkg::FL_DOUBLE]) begin
								a.flags[ttad_pkg::FL_HOLD] = 1'b0;
							end
							a.flags[ttad_pkg::FL_DOUBLE] = 1'b0;
						end
						ttad_pkg::C_DOUBLE_HT: begin
							if (!attr_cur.flags[ttad_pkg::FL_DOUBLE]) begin
								a.flags[ttad_pkg::FL_HOLD] = 1'b0;
							end
							a.flags[ttad_pkg::FL_DOUBLE] = 1'b1;
						end
						ttad_pkg::C_CONCEAL:   a.flags[ttad_pkg::FL_CONCEAL] = 1'b1;
						ttad_pkg::C_CONTIG:    a.flags[ttad_pkg::FL_SEPARATED] = 1'b0;
						ttad_pkg::C_SEPARATED: a.flags[ttad_pkg::FL_SEPARATED] = 1'b1;
						ttad_pkg::C_BLACK_BG:  a.paper = 3'd0;
						ttad_pkg::C_NEW_BG:    a.paper = attr_cur.ink;
						ttad_pkg::C_HOLD:      a.flags[ttad_pkg::FL_HOLD] = 1'b1;
						ttad_pkg::C_RELEASE:   a.flags[ttad_pkg::FL_HOLD] = 1'b0;
						default: ;
					endcase
				end
			end
		end else begin
			res.glyph_code = c5;
			unique case (chr[6:5])
				2'b01: res.glyph_set = attr_cur.flags[ttad_pkg::FL_GFX] ?
				                       ttad_pkg::GS_GFX_LOW : ttad_pkg::GS_ALPHA_LOW;
				2'b10: res.glyph_set = ttad_pkg::GS_ALPHA_MID;
				default: res.glyph_set = attr_cur.flags[ttad_pkg::FL_GFX] ?
				                         ttad_pkg::GS_GFX_HIGH : ttad_pkg::GS_ALPHA_HIGH;
			endcase
		end

		res.attr        = accepted ? a : attr_cur;
		col_wide        = 8'(col_cur);
		row_wide        = 8'(row_cur);
		res.cell_column = col_wide[5:0];
		res.cell_row    = row_wide[4:0];

		col_inc  = 8'(col_cur) + 8'd1;
		row_inc  = 7'(row_cur) + 7'd1;
		attr_nxt = res.attr;
		col_nxt  = col_cur;
		row_nxt  = row_cur;
		if (accepted) begin
			if (col_inc >= width_eff) begin
				attr_nxt = ttad_pkg::ATTR_RST;
				col_nxt  = '0;
				if (row_inc >= height_eff) begin
					row_nxt    = '0;
					res.status = ttad_pkg::ST_PAGE_WRAP;
				end else begin
					row_nxt    = row_inc[RW-1:0];
					res.status = ttad_pkg::ST_LINE_WRAP;
				end
			end else begin
				col_nxt = col_inc[CW-1:0];
			end
		end
	end

endmodule

// ----- sv/teletext_attribute_decoder.sv -----
// Top level: teletext serial attribute decoder with config and result skid.
// Each accepted result is registered in out_q, or in skid_q while the output stalls.
// Throughput: one character per cycle while in_stall is low; the attribute and cursor
// update is a single pass of logic from the input port into the result register.
// A two-entry output buffer accepts one more character while out_stall is high.
// Reset: cursor at 0,0, white ink on black paper, flags and box off, 40 x 25 cells.
module teletext_attribute_decoder #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] chr,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [2:0] glyph_set,
	output logic [4:0] glyph_code,
	output logic [1:0] held_when,
	output logic [2:0] ink,
	output logic [2:0] paper,
	output logic [5:0] attr_flags,
	output logic [1:0] box_state,
	output logic [5:0] cell_column,
	output logic [4:0] cell_row
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [6:0]        columns_q;
	logic [5:0]        rows_q;
	logic              black_ink_q;
	ttad_pkg::attr_t   attr_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	ttad_pkg::attr_t   attr_nxt;
	logic [CW-1:0]     col_nxt;
	logic [RW-1:0]     row_nxt;
	ttad_pkg::result_t res;
	ttad_pkg::result_t out_q;
	ttad_pkg::result_t skid_q;
	logic              out_v_q;
	logic              skid_v_q;
	logic              take;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_v_q;
	assign take      = in_valid && !skid_v_q;
	assign out_free  = !out_v_q || !out_stall;

	ttad_decode #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_decode (
		.chr             (chr),
		.attr_cur        (attr_q),
		.col_cur         (col_q),
		.row_cur         (row_q),
		.columns         (columns_q),
		.rows            (rows_q),
		.black_ink_enable(black_ink_q),
		.attr_nxt        (attr_nxt),
		.col_nxt         (col_nxt),
		.row_nxt         (row_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q   <= ttad_pkg::COLUMNS_RST;
			rows_q      <= ttad_pkg::ROWS_RST;
			black_ink_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ttad_pkg::REG_COLUMNS:   columns_q   <= cfg_data;
				ttad_pkg::REG_ROWS:      rows_q      <= cfg_data[5:0];
				ttad_pkg::REG_BLACK_INK: black_ink_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ttad_pkg::ATTR_RST;
			col_q  <= '0;
			row_q  <= '0;
		end else if (take) begin
			attr_q <= attr_nxt;
			col_q  <= col_nxt;
			row_q  <= row_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= res;
			end
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_v_q;
	assign status      = out_q.status;
	assign glyph_set   = out_q.glyph_set;
	assign glyph_code  = out_q.glyph_code;
	assign held_when   = out_q.held_when;
	assign ink         = out_q.attr.ink;
	assign paper       = out_q.attr.paper;
	assign attr_flags  = out_q.attr.flags;
	assign box_state   = out_q.attr.box;
	assign cell_column = out_q.cell_column;
	assign cell_row    = out_q.cell_row;

endmodule
